@@ hdl/pket_pkg.sv @@
`default_nettype none
package pket_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCESS_NOISE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEASUREMENT_NOISE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_COV       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_WORK        = 3'd3;

   localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MULQ = 3'd2;
   localparam logic [2:0] OP_MULK = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_SQRT = 3'd5;

   localparam logic [4:0] R_ZERO = 5'd0;
   localparam logic [4:0] R_ONE  = 5'd1;
   localparam logic [4:0] R_TWO  = 5'd2;
   localparam logic [4:0] R_POS  = 5'd3;
   localparam logic [4:0] R_VEL  = 5'd4;
   localparam logic [4:0] R_PP   = 5'd5;
   localparam logic [4:0] R_PV   = 5'd6;
   localparam logic [4:0] R_VP   = 5'd7;
   localparam logic [4:0] R_VV   = 5'd8;
   localparam logic [4:0] R_Q    = 5'd9;
   localparam logic [4:0] R_RN   = 5'd10;
   localparam logic [4:0] R_DT   = 5'd11;
   localparam logic [4:0] R_MEAS = 5'd12;
   localparam logic [4:0] R_TOT  = 5'd13;
   localparam logic [4:0] R_T0   = 5'd14;
   localparam logic [4:0] R_T1   = 5'd15;
   localparam logic [4:0] R_T2   = 5'd16;
   localparam logic [4:0] R_T3   = 5'd17;

   localparam int PC_BITS = 6;
   localparam logic [PC_BITS-1:0] PC_OUT = 6'd29;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] dst;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic       last;
   } uop_type;

   function automatic uop_type mk(input logic [2:0] op, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b,
                                  input logic last);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = a;
      u.src_b = b;
      u.last  = last;
      return u;
   endfunction

   // filter step, then the estimate
   function automatic uop_type uop_rom(input logic [PC_BITS-1:0] pc);
      uop_type u;
      unique case (pc)
         6'd0: u = mk(OP_MULK, R_T0, R_VEL, R_DT, 1'b0);
         6'd1: u = mk(OP_ADD, R_POS, R_POS, R_T0, 1'b0);
         6'd2: u = mk(OP_MULK, R_T0, R_VV, R_DT, 1'b0);
         6'd3: u = mk(OP_ADD, R_T1, R_PV, R_T0, 1'b0);
         6'd4: u = mk(OP_MULK, R_T0, R_VP, R_DT, 1'b0);
         6'd5: u = mk(OP_ADD, R_T2, R_PP, R_T0, 1'b0);
         6'd6: u = mk(OP_MULK, R_T0, R_T1, R_DT, 1'b0);
         6'd7: u = mk(OP_ADD, R_T2, R_T2, R_T0, 1'b0);
         6'd8: u = mk(OP_ADD, R_PP, R_T2, R_Q, 1'b0);
         6'd9: u = mk(OP_ADD, R_PV, R_T1, R_ZERO, 1'b0);
         6'd10: u = mk(OP_MULK, R_T0, R_VV, R_DT, 1'b0);
         6'd11: u = mk(OP_ADD, R_VP, R_VP, R_T0, 1'b0);
         6'd12: u = mk(OP_ADD, R_VV, R_VV, R_Q, 1'b0);
         6'd13: u = mk(OP_ADD, R_T0, R_PP, R_RN, 1'b0);
         6'd14: u = mk(OP_DIV, R_T1, R_PP, R_T0, 1'b0);
         6'd15: u = mk(OP_DIV, R_T2, R_VP, R_T0, 1'b0);
         6'd16: u = mk(OP_SUB, R_T3, R_MEAS, R_POS, 1'b0);
         6'd17: u = mk(OP_MULQ, R_T0, R_T1, R_T3, 1'b0);
         6'd18: u = mk(OP_ADD, R_POS, R_POS, R_T0, 1'b0);
         6'd19: u = mk(OP_MULQ, R_T0, R_T2, R_T3, 1'b0);
         6'd20: u = mk(OP_ADD, R_VEL, R_VEL, R_T0, 1'b0);
         6'd21: u = mk(OP_SUB, R_T1, R_ONE, R_T1, 1'b0);
         6'd22: u = mk(OP_SUB, R_T2, R_ZERO, R_T2, 1'b0);
         6'd23: u = mk(OP_MULQ, R_T0, R_T2, R_PP, 1'b0);
         6'd24: u = mk(OP_ADD, R_VP, R_T0, R_VP, 1'b0);
         6'd25: u = mk(OP_MULQ, R_T0, R_T2, R_PV, 1'b0);
         6'd26: u = mk(OP_ADD, R_VV, R_T0, R_VV, 1'b0);
         6'd27: u = mk(OP_MULQ, R_PP, R_T1, R_PP, 1'b0);
         6'd28: u = mk(OP_MULQ, R_PV, R_T1, R_PV, 1'b1);
         6'd29: u = mk(OP_SUB, R_T0, R_TOT, R_POS, 1'b0);
         6'd30: u = mk(OP_DIV, R_T1, R_T0, R_VEL, 1'b0);
         6'd31: u = mk(OP_MULQ, R_T0, R_T1, R_T1, 1'b0);
         6'd32: u = mk(OP_MULQ, R_T0, R_T0, R_VV, 1'b0);
         6'd33: u = mk(OP_MULQ, R_T2, R_T1, R_PV, 1'b0);
         6'd34: u = mk(OP_MULK, R_T2, R_T2, R_TWO, 1'b0);
         6'd35: u = mk(OP_SUB, R_T0, R_T0, R_T2, 1'b0);
         6'd36: u = mk(OP_ADD, R_T0, R_T0, R_PP, 1'b0);
         6'd37: u = mk(OP_DIV, R_T0, R_T0, R_VEL, 1'b0);
         6'd38: u = mk(OP_DIV, R_T0, R_T0, R_VEL, 1'b0);
         6'd39: u = mk(OP_SQRT, R_T2, R_T0, R_ZERO, 1'b1);
         default: u = mk(OP_ADD, R_T0, R_ZERO, R_ZERO, 1'b1);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

@@ hdl/progress_kalman_eta_estimator_unit.sv @@
// Progress ETA estimator: a two-state position/velocity Kalman filter in signed
// Q(64-FRAC_BITS).FRAC_BITS that returns one remaining-time estimate and its
// one-sigma spread per request. A small microcode sequencer drives one shared
// arithmetic unit: saturating add/subtract, a 64x64 product from four
// 32x32 partial products, a restoring divider at one quotient bit per cycle
// and a square root at one root bit per cycle. A request that advances the
// filter runs the filter step and then the estimate, its time dominated by
// the five divisions; a seeding or stale request takes the estimate part
// only. With no positive velocity any request skips the estimate and returns
// zeros marked invalid. One request is in flight at a time; the next is taken
// once the response has been accepted.
`default_nettype none
module progress_kalman_eta_estimator_unit import pket_pkg::*; #(
   parameter int FRAC_BITS = 32,
   parameter int TIME_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [31:0]               req_progress_sample,
   input  wire logic [31:0]               req_sample_time,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [47:0]                    rsp_remaining_time,
   output logic [47:0]                    rsp_time_sigma,
   output logic                           rsp_estimate_valid,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]               csr_write_data
);

   localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
   localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);
   localparam logic [6:0] DIV_ITERS = 7'(64 + FRAC_BITS);
   localparam logic [6:0] SQRT_ITERS = 7'd64;
   localparam logic [6:0] MUL_STEPS = 7'd4;
   localparam int RND_SH = (FRAC_BITS > 16) ? FRAC_BITS - 17 : 0;
   localparam logic [64:0] RND = (FRAC_BITS > 16) ? (65'd1 << RND_SH) : 65'd0;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   function automatic logic [63:0] pack(input logic neg, input logic [127:0] m);
      if (|m[127:63]) return neg ? Q_MIN : Q_MAX;
      return neg ? (64'd0 - m[63:0]) : m[63:0];
   endfunction

   function automatic logic [63:0] from_int(input logic [31:0] u);
      logic [95:0] w;
      w = {64'd0, u} << FRAC_BITS;
      if (|w[95:63]) return Q_MAX;
      return w[63:0];
   endfunction

   function automatic logic [63:0] from_q16(input logic [31:0] u);
      logic [63:0] w;
      w = {32'd0, u} << (FRAC_BITS - 16);
      return w;
   endfunction

   function automatic logic [47:0] to_out(input logic [63:0] t);
      logic [64:0] m;
      if (t[63] || t == 64'd0) return 48'd0;
      m = ({1'b0, t} + RND) >> (FRAC_BITS - 16);
      if (|m[64:48]) return {48{1'b1}};
      return m[47:0];
   endfunction

   logic [31:0] pn_ff, pn_in, mn_ff, mn_in, ic_ff, ic_in, tw_ff, tw_in;
   logic [2:0] state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic phase_ff, phase_in, seeded_ff, seeded_in;
   logic [TW-1:0] prev_ff, prev_in, dt_ff, dt_in;
   logic [31:0] meas_ff, meas_in;
   logic [63:0] pos_ff, pos_in, vel_ff, vel_in, pp_ff, pp_in, pv_ff, pv_in;
   logic [63:0] vp_ff, vp_in, vv_ff, vv_in;
   logic [63:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   uop_type uop_ff, uop_in;
   logic neg_ff, neg_in, zf_ff, zf_in, dz_ff, dz_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in, root_ff, root_in;
   logic [127:0] acc_ff, acc_in;
   logic [67:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [47:0] rto_ff, rto_in, sgo_ff, sgo_in;
   logic est_ff, est_in;

   uop_type cur;
   logic [63:0] opa, opb, res;
   logic [31:0] pa, pb;
   logic [63:0] prod;
   logic [6:0] psh;
   logic [64:0] rr;
   logic [67:0] rs, trial;
   logic [127:0] qr;
   logic [TW-1:0] now;
   logic done;

   assign cur = uop_rom(pc_ff);
   assign now = req_sample_time[TW-1:0];

   always_comb begin
      unique case (cur.src_a)
         R_ONE:  opa = ONE_Q;
         R_TWO:  opa = 64'd2;
         R_POS:  opa = pos_ff;
         R_VEL:  opa = vel_ff;
         R_PP:   opa = pp_ff;
         R_PV:   opa = pv_ff;
         R_VP:   opa = vp_ff;
         R_VV:   opa = vv_ff;
         R_Q:    opa = from_q16(pn_ff);
         R_RN:   opa = from_q16(mn_ff);
         R_DT:   opa = 64'(dt_ff);
         R_MEAS: opa = from_int(meas_ff);
         R_TOT:  opa = from_int(tw_ff);
         R_T0:   opa = t0_ff;
         R_T1:   opa = t1_ff;
         R_T2:   opa = t2_ff;
         R_T3:   opa = t3_ff;
         default: opa = 64'd0;
      endcase
      unique case (cur.src_b)
         R_ONE:  opb = ONE_Q;
         R_TWO:  opb = 64'd2;
         R_POS:  opb = pos_ff;
         R_VEL:  opb = vel_ff;
         R_PP:   opb = pp_ff;
         R_PV:   opb = pv_ff;
         R_VP:   opb = vp_ff;
         R_VV:   opb = vv_ff;
         R_Q:    opb = from_q16(pn_ff);
         R_RN:   opb = from_q16(mn_ff);
         R_DT:   opb = 64'(dt_ff);
         R_MEAS: opb = from_int(meas_ff);
         R_TOT:  opb = from_int(tw_ff);
         R_T0:   opb = t0_ff;
         R_T1:   opb = t1_ff;
         R_T2:   opb = t2_ff;
         R_T3:   opb = t3_ff;
         default: opb = 64'd0;
      endcase
   end

   // shared datapath: one 32x32 multiplier, plus the divider and square-root subtract-compares
   always_comb begin
      pa    = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      pb    = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      prod  = {32'd0, pa} * {32'd0, pb};
      psh   = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0], 5'd0};
      rr    = {rem_ff[63:0], acc_ff[127]};
      rs    = {rem_ff[65:0], acc_ff[127:126]};
      trial = {2'd0, root_ff, 2'b01};
      qr    = acc_ff + {127'd0, ({rem_ff[63:0], 1'b0} >= {1'b0, mb_ff})};
      done  = 1'b0;
      res   = 64'd0;
      unique case (uop_ff.op)
         OP_ADD: begin
            done = 1'b1;
            res  = sat_add(ma_ff, mb_ff);
         end
         OP_SUB: begin
            done = 1'b1;
            res  = sat_sub(ma_ff, mb_ff);
         end
         OP_MULQ: begin
            done = (cnt_ff == MUL_STEPS);
            res  = pack(neg_ff, (acc_ff + HALF) >> FRAC_BITS);
         end
         OP_MULK: begin
            done = (cnt_ff == MUL_STEPS);
            res  = pack(neg_ff, acc_ff);
         end
         OP_DIV: begin
            done = (cnt_ff == DIV_ITERS);
            priority if (zf_ff) res = 64'd0;
            else if (dz_ff) res = ma_ff[63] ? Q_MIN : Q_MAX;
            else res = pack(neg_ff, qr);
         end
         OP_SQRT: begin
            done = (cnt_ff == SQRT_ITERS);
            priority if (zf_ff) res = 64'd0;
            else if (root_ff[63]) res = Q_MAX;
            else res = root_ff;
         end
         default: begin
            done = 1'b1;
            res  = 64'd0;
         end
      endcase
   end

   always_comb begin
      pn_in = pn_ff; mn_in = mn_ff; ic_in = ic_ff; tw_in = tw_ff;
      state_in = state_ff; pc_in = pc_ff; phase_in = phase_ff; seeded_in = seeded_ff;
      prev_in = prev_ff; dt_in = dt_ff; meas_in = meas_ff;
      pos_in = pos_ff; vel_in = vel_ff; pp_in = pp_ff; pv_in = pv_ff;
      vp_in = vp_ff; vv_in = vv_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff;
      uop_in = uop_ff; neg_in = neg_ff; zf_in = zf_ff; dz_in = dz_ff;
      ma_in = ma_ff; mb_in = mb_ff; root_in = root_ff; acc_in = acc_ff;
      rem_in = rem_ff; cnt_in = cnt_ff;
      rto_in = rto_ff; sgo_in = sgo_ff; est_in = est_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     pn_in = csr_write_data;
            CSR_MEASUREMENT_NOISE: mn_in = csr_write_data;
            CSR_INITIAL_COV:       ic_in = csr_write_data;
            CSR_TOTAL_WORK:        tw_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in = req_progress_sample;
               priority if (!seeded_ff) begin
                  pos_in    = from_int(req_progress_sample);
                  vel_in    = 64'd0;
                  pp_in     = from_q16(ic_ff);
                  vv_in     = from_q16(ic_ff);
                  pv_in     = 64'd0;
                  vp_in     = 64'd0;
                  prev_in   = now;
                  seeded_in = 1'b1;
                  state_in  = ST_CHECK;
               end else if (now > prev_ff) begin
                  dt_in    = now - prev_ff;
                  prev_in  = now;
                  pc_in    = '0;
                  phase_in = 1'b0;
                  state_in = ST_ISSUE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!vel_ff[63] && vel_ff != 64'd0) begin
               pc_in    = PC_OUT;
               phase_in = 1'b1;
               state_in = ST_ISSUE;
            end else begin
               rto_in   = 48'd0;
               sgo_in   = 48'd0;
               est_in   = 1'b0;
               state_in = ST_RESP;
            end
         end
         ST_ISSUE: begin
            uop_in   = cur;
            cnt_in   = 7'd0;
            acc_in   = 128'd0;
            rem_in   = 68'd0;
            root_in  = 64'd0;
            ma_in    = opa;
            mb_in    = opb;
            neg_in   = opa[63] ^ opb[63];
            zf_in    = (opa == 64'd0);
            dz_in    = (opb == 64'd0);
            state_in = ST_EXEC;
            unique case (cur.op)
               OP_MULQ: begin
                  ma_in = mag(opa);
                  mb_in = mag(opb);
               end
               OP_MULK: begin
                  ma_in  = mag(opa);
                  neg_in = opa[63];
               end
               OP_DIV: begin
                  mb_in  = mag(opb);
                  acc_in = {mag(opa), 64'd0};
               end
               OP_SQRT: begin
                  acc_in = {opa, 64'd0} >> (64 - FRAC_BITS);
                  zf_in  = opa[63] || (opa == 64'd0);
               end
               default: ;
            endcase
         end
         ST_EXEC: begin
            if (!done) begin
               cnt_in = cnt_ff + 7'd1;
               unique case (uop_ff.op)
                  OP_MULQ, OP_MULK: acc_in = acc_ff + ({64'd0, prod} << psh);
                  OP_DIV: begin
                     if (rr >= {1'b0, mb_ff}) begin
                        rem_in = {3'd0, rr - {1'b0, mb_ff}};
                        acc_in = {acc_ff[126:0], 1'b1};
                     end else begin
                        rem_in = {3'd0, rr};
                        acc_in = {acc_ff[126:0], 1'b0};
                     end
                  end
                  OP_SQRT: begin
                     acc_in = {acc_ff[125:0], 2'd0};
                     if (rs >= trial) begin
                        rem_in  = rs - trial;
                        root_in = {root_ff[62:0], 1'b1};
                     end else begin
                        rem_in  = rs;
                        root_in = {root_ff[62:0], 1'b0};
                     end
                  end
                  default: ;
               endcase
            end else begin
               unique case (uop_ff.dst)
                  R_POS: pos_in = res;
                  R_VEL: vel_in = res;
                  R_PP:  pp_in  = res;
                  R_PV:  pv_in  = res;
                  R_VP:  vp_in  = res;
                  R_VV:  vv_in  = res;
                  R_T0:  t0_in  = res;
                  R_T1:  t1_in  = res;
                  R_T2:  t2_in  = res;
                  R_T3:  t3_in  = res;
                  default: ;
               endcase
               priority if (!uop_ff.last) begin
                  pc_in    = pc_ff + PC_BITS'(1);
                  state_in = ST_ISSUE;
               end else if (phase_ff) begin
                  rto_in   = to_out(t1_ff);
                  sgo_in   = to_out(res);
                  est_in   = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff     <= 32'd65536;
         mn_ff     <= 32'd65536;
         ic_ff     <= 32'd65536;
         tw_ff     <= 32'd0;
         state_ff  <= ST_IDLE;
         seeded_ff <= 1'b0;
         prev_ff   <= '0;
         pos_ff    <= 64'd0;
         vel_ff    <= 64'd0;
         pp_ff     <= ONE_Q;
         pv_ff     <= 64'd0;
         vp_ff     <= 64'd0;
         vv_ff     <= ONE_Q;
      end else begin
         pn_ff     <= pn_in;
         mn_ff     <= mn_in;
         ic_ff     <= ic_in;
         tw_ff     <= tw_in;
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
         prev_ff   <= prev_in;
         pos_ff    <= pos_in;
         vel_ff    <= vel_in;
         pp_ff     <= pp_in;
         pv_ff     <= pv_in;
         vp_ff     <= vp_in;
         vv_ff     <= vv_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff    <= pc_in;
      phase_ff <= phase_in;
      dt_ff    <= dt_in;
      meas_ff  <= meas_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      t3_ff    <= t3_in;
      uop_ff   <= uop_in;
      neg_ff   <= neg_in;
      zf_ff    <= zf_in;
      dz_ff    <= dz_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      root_ff  <= root_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      rto_ff   <= rto_in;
      sgo_ff   <= sgo_in;
      est_ff   <= est_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_remaining_time = rto_ff;
   assign rsp_time_sigma     = sgo_ff;
   assign rsp_estimate_valid = est_ff;

`ifndef ASSERT_OFF
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready and response valid together");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_estimate_valid |-> rsp_remaining_time == 48'd0 &&
      rsp_time_sigma == 48'd0)
      else $error("invalid estimate with nonzero fields");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a request");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not idle after response");
   a_seeded_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seeded_ff)
      else $error("response before seeding");
`endif

endmodule
`default_nettype wire
